FILE: rtl/core/dhfk_pkg.sv
package dhfk_pkg;

    // fixed-point scales
    localparam int Q = 30;
    localparam int ANGLE_W = 16;
    localparam int REG_W = 18;
    localparam int LINK_W = 26;
    localparam int ROT_OUT_W = 18;
    localparam int POS_OUT_W = 19;

    // one full stage of the sine pipeline per register, phase in to value out
    localparam int SIN_LAT = 9;

    // configuration register indexes
    localparam logic [2:0] CFG_BASE_HEIGHT = 3'd0;
    localparam logic [2:0] CFG_UPPER_ARM = 3'd1;
    localparam logic [2:0] CFG_FOREARM = 3'd2;
    localparam logic [2:0] CFG_WRIST_ONE = 3'd3;
    localparam logic [2:0] CFG_WRIST_TWO = 3'd4;
    localparam logic [2:0] CFG_WRIST_THREE = 3'd5;

    // register reset values, meters in Q2.16
    localparam logic signed [17:0] RST_BASE_HEIGHT = 18'sd5843;
    localparam logic signed [17:0] RST_UPPER_ARM = -18'sd27853;
    localparam logic signed [17:0] RST_FOREARM = -18'sd25706;
    localparam logic signed [17:0] RST_WRIST_ONE = 18'sd7153;
    localparam logic signed [17:0] RST_WRIST_TWO = 18'sd6197;
    localparam logic signed [17:0] RST_WRIST_THREE = 18'sd5394;

    // odd taylor coefficients of sine, Q30
    localparam logic [31:0] SIN_C1 = 32'd1686629713;
    localparam logic [31:0] SIN_C11 = 32'd3864;
    localparam logic [31:0] SIN_COEF [4] = '{32'd172272, 32'd5026995, 32'd85569306,
                                              32'd693598668};

    // link twist: zero, plus or minus a quarter turn
    localparam int TWIST [6] = '{0, 1, 0, 0, 1, -1};

    typedef logic signed [32:0] rot_t;
    typedef logic signed [35:0] pos_t;
    typedef logic signed [25:0] link_t;

    localparam rot_t ROT_ONE = 33'sh040000000;

    // running base-to-link transform, rotation Q30, position in link units
    typedef struct packed {
        rot_t [2:0][2:0] rot;
        pos_t [2:0]      pos;
    } pose_t;

    // stage handshake control
    typedef struct packed {
        logic en;
        logic valid;
    } stage_ctl_t;

endpackage

FILE: rtl/core/dhfk_sin.sv
module dhfk_sin (
    input  logic                clk,
    input  logic                en,
    input  logic [31:0]         phase,
    output dhfk_pkg::rot_t      sin_val
);

    logic [30:0] t_in;
    logic [30:0] t_reg [0:6];
    logic        neg_reg [0:7];
    logic [61:0] sq_reg;
    logic [30:0] t2_reg [0:4];
    logic [62:0] hp_reg [0:4];
    logic [31:0] acc [0:3];
    logic [31:0] acc_last;
    logic [62:0] fp_reg;
    logic [32:0] mag;
    dhfk_pkg::rot_t sin_reg;

    // fold the phase to a quarter wave
    assign t_in = phase[30] ? (31'h40000000 - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};

    // horner step terms
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            acc[k] = dhfk_pkg::SIN_COEF[k] - 32'(hp_reg[k] >> dhfk_pkg::Q);
        end
        acc_last = dhfk_pkg::SIN_C1 - 32'(hp_reg[4] >> dhfk_pkg::Q);
        mag = fp_reg[62:30];
    end

    // pipeline: input register, square, five horner steps, final product, sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0]   <= t_in;
            neg_reg[0] <= phase[31];
            for (int k = 1; k < 7; k++)
            begin
                t_reg[k] <= t_reg[k-1];
            end
            for (int k = 1; k < 8; k++)
            begin
                neg_reg[k] <= neg_reg[k-1];
            end
            sq_reg    <= 62'(t_reg[0]) * 62'(t_reg[0]);
            t2_reg[0] <= sq_reg[60:30];
            hp_reg[0] <= 63'(sq_reg[60:30]) * 63'(dhfk_pkg::SIN_C11);
            for (int k = 0; k < 4; k++)
            begin
                t2_reg[k+1] <= t2_reg[k];
                hp_reg[k+1] <= 63'(t2_reg[k]) * 63'(acc[k]);
            end
            fp_reg  <= 63'(t_reg[6]) * 63'(acc_last);
            sin_reg <= neg_reg[7] ? -$signed(mag) : $signed(mag);
        end
    end

    assign sin_val = sin_reg;

endmodule

FILE: rtl/core/dhfk_link.sv
module dhfk_link #(
    parameter int TWIST = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dhfk_pkg::stage_ctl_t  ctl,
    input  dhfk_pkg::pose_t       pose_in,
    input  dhfk_pkg::rot_t        sin_val,
    input  dhfk_pkg::rot_t        cos_val,
    input  dhfk_pkg::link_t       la,
    input  dhfk_pkg::link_t       ld,
    output logic                  out_valid,
    output dhfk_pkg::pose_t       pose_out
);

    localparam logic signed [66:0] RND = 67'sd1 <<< (dhfk_pkg::Q - 1);

    logic signed [65:0] m_reg [3][4];
    logic signed [58:0] pa_reg [3];
    logic signed [58:0] pb_reg [3];
    dhfk_pkg::rot_t     r2_reg [3];
    dhfk_pkg::pos_t     p_reg [3];
    logic               v1_reg;
    logic               v2_reg;
    dhfk_pkg::pose_t    pose_reg;

    dhfk_pkg::rot_t     r0 [3];
    dhfk_pkg::rot_t     rs [3];
    dhfk_pkg::rot_t     rp [3];
    dhfk_pkg::rot_t     r2 [3];
    logic signed [66:0] sum0 [3];
    logic signed [66:0] sum1 [3];
    logic signed [66:0] psum [3];
    dhfk_pkg::pose_t    pose_next;

    // column picks for this twist
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            r0[i] = pose_in.rot[i][0];
            rs[i] = (TWIST == 0) ? pose_in.rot[i][1] : pose_in.rot[i][2];
            rp[i] = (TWIST == 0) ? pose_in.rot[i][2] : pose_in.rot[i][1];
            if (TWIST == 0)
            begin
                r2[i] = pose_in.rot[i][2];
            end
            else if (TWIST > 0)
            begin
                r2[i] = -pose_in.rot[i][1];
            end
            else
            begin
                r2[i] = pose_in.rot[i][1];
            end
        end
    end

    // stage one: products
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m_reg[i][0] <= 66'(r0[i]) * 66'(cos_val);
                m_reg[i][1] <= 66'(rs[i]) * 66'(sin_val);
                m_reg[i][2] <= 66'(r0[i]) * 66'(sin_val);
                m_reg[i][3] <= 66'(rs[i]) * 66'(cos_val);
                pa_reg[i]   <= 59'(r0[i]) * 59'(la);
                pb_reg[i]   <= 59'(rp[i]) * 59'(ld);
                r2_reg[i]   <= r2[i];
                p_reg[i]    <= pose_in.pos[i];
            end
        end
    end

    // stage two: sums with one rounding each
    always_comb
    begin
        pose_next = pose_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (TWIST < 0)
            begin
                sum0[i] = 67'(m_reg[i][0]) - 67'(m_reg[i][1]);
                sum1[i] = -67'(m_reg[i][2]) - 67'(m_reg[i][3]);
            end
            else
            begin
                sum0[i] = 67'(m_reg[i][0]) + 67'(m_reg[i][1]);
                sum1[i] = 67'(m_reg[i][3]) - 67'(m_reg[i][2]);
            end
            if (TWIST > 0)
            begin
                psum[i] = 67'(pa_reg[i]) - 67'(pb_reg[i]);
            end
            else
            begin
                psum[i] = 67'(pa_reg[i]) + 67'(pb_reg[i]);
            end
            pose_next.rot[i][0] = 33'((sum0[i] + RND) >>> dhfk_pkg::Q);
            pose_next.rot[i][1] = 33'((sum1[i] + RND) >>> dhfk_pkg::Q);
            pose_next.rot[i][2] = r2_reg[i];
            pose_next.pos[i]    = p_reg[i] + 36'((psum[i] + RND) >>> dhfk_pkg::Q);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            pose_reg <= pose_next;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            v1_reg <= ctl.valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign pose_out  = pose_reg;

endmodule

FILE: rtl/core/dh_forward_kinematics_six_joint_unit.sv
// Forward kinematics of a six-joint arm, modified Denavit-Hartenberg links with
// twists 0, +90, 0, 0, +90 and -90 degrees. One set of six joint angles is taken
// per cycle; the whole pipeline advances together and holds while the result
// is not taken. A set passes one input register, nine sine/cosine pipeline
// stages, two per joint for the 3x3 matrix chain and one output register. Link
// lengths and offsets are written through the cfg channel (index 0..5, higher
// indexes ignored), by the user only while idle; the unit does not enforce it.
// Rotation entries are Q2.16 clamped to +-1; positions are saturated to 19 bits.
module dh_forward_kinematics_six_joint_unit #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [17:0]         cfg_data,
    input  logic                angle_valid,
    output logic                angle_ready,
    input  logic signed [15:0]  angle_joint_one,
    input  logic signed [15:0]  angle_joint_two,
    input  logic signed [15:0]  angle_joint_three,
    input  logic signed [15:0]  angle_joint_four,
    input  logic signed [15:0]  angle_joint_five,
    input  logic signed [15:0]  angle_joint_six,
    output logic                pose_valid,
    input  logic                pose_ready,
    output logic signed [17:0]  rot_row0_col0,
    output logic signed [17:0]  rot_row0_col1,
    output logic signed [17:0]  rot_row0_col2,
    output logic signed [17:0]  rot_row1_col0,
    output logic signed [17:0]  rot_row1_col1,
    output logic signed [17:0]  rot_row1_col2,
    output logic signed [17:0]  rot_row2_col0,
    output logic signed [17:0]  rot_row2_col1,
    output logic signed [17:0]  rot_row2_col2,
    output logic signed [18:0]  pos_x,
    output logic signed [18:0]  pos_y,
    output logic signed [18:0]  pos_z
);

    localparam int VLAT = dhfk_pkg::SIN_LAT + 1;
    localparam logic signed [34:0] ROT_RND = 35'sd1 <<< (dhfk_pkg::Q - 1 - FRAC_BITS);
    localparam logic signed [34:0] ROT_MAX = 35'sd1 <<< FRAC_BITS;
    localparam logic signed [36:0] POS_MAX = 37'sd262143;
    localparam logic signed [36:0] POS_MIN = -37'sd262144;

    logic signed [17:0] base_height_reg;
    logic signed [17:0] upper_arm_reg;
    logic signed [17:0] forearm_reg;
    logic signed [17:0] wrist_one_reg;
    logic signed [17:0] wrist_two_reg;
    logic signed [17:0] wrist_three_reg;

    logic                 en;
    dhfk_pkg::stage_ctl_t ctl [7];
    logic                 vpipe_reg [VLAT];
    logic [15:0]          angle_in [6];
    dhfk_pkg::link_t      la_w [6];
    dhfk_pkg::link_t      ld_w [6];
    dhfk_pkg::pose_t      pose_w [7];
    logic                 valid_w [7];

    logic signed [17:0] rot_out_reg [9];
    logic signed [18:0] pos_out_reg [3];
    logic               pose_valid_reg;
    logic signed [17:0] rot_next [9];
    logic signed [18:0] pos_next [3];
    logic signed [34:0] rot_r;
    logic signed [36:0] pos_r;

    // whole pipeline moves unless the result is held
    assign en          = !pose_valid_reg || pose_ready;
    assign angle_ready = en;
    assign cfg_ready   = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_height_reg <= dhfk_pkg::RST_BASE_HEIGHT;
            upper_arm_reg   <= dhfk_pkg::RST_UPPER_ARM;
            forearm_reg     <= dhfk_pkg::RST_FOREARM;
            wrist_one_reg   <= dhfk_pkg::RST_WRIST_ONE;
            wrist_two_reg   <= dhfk_pkg::RST_WRIST_TWO;
            wrist_three_reg <= dhfk_pkg::RST_WRIST_THREE;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                dhfk_pkg::CFG_BASE_HEIGHT: base_height_reg <= cfg_data;
                dhfk_pkg::CFG_UPPER_ARM:   upper_arm_reg   <= cfg_data;
                dhfk_pkg::CFG_FOREARM:     forearm_reg     <= cfg_data;
                dhfk_pkg::CFG_WRIST_ONE:   wrist_one_reg   <= cfg_data;
                dhfk_pkg::CFG_WRIST_TWO:   wrist_two_reg   <= cfg_data;
                dhfk_pkg::CFG_WRIST_THREE: wrist_three_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // link lengths and offsets with eight guard bits
    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            la_w[j] = '0;
            ld_w[j] = '0;
        end
        ld_w[0] = $signed({base_height_reg, 8'd0});
        la_w[2] = $signed({upper_arm_reg, 8'd0});
        la_w[3] = $signed({forearm_reg, 8'd0});
        ld_w[3] = $signed({wrist_one_reg, 8'd0});
        ld_w[4] = $signed({wrist_two_reg, 8'd0});
        ld_w[5] = $signed({wrist_three_reg, 8'd0});
    end

    assign angle_in[0] = angle_joint_one;
    assign angle_in[1] = angle_joint_two;
    assign angle_in[2] = angle_joint_three;
    assign angle_in[3] = angle_joint_four;
    assign angle_in[4] = angle_joint_five;
    assign angle_in[5] = angle_joint_six;

    // valid bits through the input register and sine pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < VLAT; k++)
            begin
                vpipe_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vpipe_reg[0] <= angle_valid;
            for (int k = 1; k < VLAT; k++)
            begin
                vpipe_reg[k] <= vpipe_reg[k-1];
            end
        end
    end

    // identity transform enters the chain
    always_comb
    begin
        pose_w[0] = '0;
        pose_w[0].rot[0][0] = dhfk_pkg::ROT_ONE;
        pose_w[0].rot[1][1] = dhfk_pkg::ROT_ONE;
        pose_w[0].rot[2][2] = dhfk_pkg::ROT_ONE;
    end
    assign valid_w[0] = vpipe_reg[VLAT-1];

    // per joint: angle delay to line up with the chain, sine, cosine, link
    for (genvar gj = 0; gj < 6; gj++)
    begin : g_joint
        logic [15:0]    ang_dly_reg [0:2*gj];
        logic [31:0]    ph_sin;
        logic [31:0]    ph_cos;
        dhfk_pkg::rot_t s_w;
        dhfk_pkg::rot_t c_w;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ang_dly_reg[0] <= angle_in[gj];
                for (int k = 1; k <= 2*gj; k++)
                begin
                    ang_dly_reg[k] <= ang_dly_reg[k-1];
                end
            end
        end

        // one turn is the low ANGLE_BITS bits
        assign ph_sin = 32'(ang_dly_reg[2*gj]) << (32 - ANGLE_BITS);
        assign ph_cos = ph_sin + 32'h40000000;

        dhfk_sin u_sin (
            .clk     (clk),
            .en      (en),
            .phase   (ph_sin),
            .sin_val (s_w)
        );

        dhfk_sin u_cos (
            .clk     (clk),
            .en      (en),
            .phase   (ph_cos),
            .sin_val (c_w)
        );

        assign ctl[gj] = '{en: en, valid: valid_w[gj]};

        dhfk_link #(
            .TWIST (dhfk_pkg::TWIST[gj])
        ) u_link (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl[gj]),
            .pose_in   (pose_w[gj]),
            .sin_val   (s_w),
            .cos_val   (c_w),
            .la        (la_w[gj]),
            .ld        (ld_w[gj]),
            .out_valid (valid_w[gj+1]),
            .pose_out  (pose_w[gj+1])
        );
    end

    assign ctl[6] = '{en: en, valid: valid_w[6]};

    // output scaling, clamp and saturation
    always_comb
    begin
        rot_r = '0;
        pos_r = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                rot_r = (35'(pose_w[6].rot[i][j]) + ROT_RND) >>> (dhfk_pkg::Q - FRAC_BITS);
                if (rot_r > ROT_MAX)
                begin
                    rot_r = ROT_MAX;
                end
                else if (rot_r < -ROT_MAX)
                begin
                    rot_r = -ROT_MAX;
                end
                rot_next[i*3+j] = rot_r[17:0];
            end
            pos_r = (37'(pose_w[6].pos[i]) + 37'sd128) >>> 8;
            if (pos_r > POS_MAX)
            begin
                pos_r = POS_MAX;
            end
            else if (pos_r < POS_MIN)
            begin
                pos_r = POS_MIN;
            end
            pos_next[i] = pos_r[18:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl[6].en)
        begin
            for (int k = 0; k < 9; k++)
            begin
                rot_out_reg[k] <= rot_next[k];
            end
            for (int k = 0; k < 3; k++)
            begin
                pos_out_reg[k] <= pos_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_valid_reg <= 1'b0;
        end
        else if (ctl[6].en)
        begin
            pose_valid_reg <= ctl[6].valid;
        end
    end

    assign pose_valid    = pose_valid_reg;
    assign rot_row0_col0 = rot_out_reg[0];
    assign rot_row0_col1 = rot_out_reg[1];
    assign rot_row0_col2 = rot_out_reg[2];
    assign rot_row1_col0 = rot_out_reg[3];
    assign rot_row1_col1 = rot_out_reg[4];
    assign rot_row1_col2 = rot_out_reg[5];
    assign rot_row2_col0 = rot_out_reg[6];
    assign rot_row2_col1 = rot_out_reg[7];
    assign rot_row2_col2 = rot_out_reg[8];
    assign pos_x         = pos_out_reg[0];
    assign pos_y         = pos_out_reg[1];
    assign pos_z         = pos_out_reg[2];

endmodule

FILE: tb/sv/dh_forward_kinematics_six_joint_unit_tb.sv
`timescale 1ns / 1ps

module dh_forward_kinematics_six_joint_unit_tb;

    // pipeline depth from the unit header, plus margin
    localparam int PIPE_DEPTH = 23;
    localparam int SETTLE_CYCLES = PIPE_DEPTH + 10;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 430;

    // sine coefficients, Q30
    localparam longint unsigned COEF_1 = 1686629713;
    localparam longint unsigned COEF_3 = 693598668;
    localparam longint unsigned COEF_5 = 85569306;
    localparam longint unsigned COEF_7 = 5026995;
    localparam longint unsigned COEF_9 = 172272;
    localparam longint unsigned COEF_11 = 3864;
    localparam longint UNIT_Q30 = 64'sd1 << 30;

    typedef enum int {TWIST_NONE, TWIST_PLUS, TWIST_MINUS} twist_kind_t;
    localparam twist_kind_t LINK_TWIST [6] = '{TWIST_NONE, TWIST_PLUS, TWIST_NONE,
                                               TWIST_NONE, TWIST_PLUS, TWIST_MINUS};

    typedef logic signed [15:0] joint_angles_t [6];

    typedef struct {
        logic signed [17:0] rot [9];
        logic signed [18:0] pos [3];
    } tool_pose_t;

    typedef struct {
        joint_angles_t angles;
        bit            typed;
        tool_pose_t    pose;
    } angle_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [17:0]        cfg_data;
    logic               angle_valid;
    logic               angle_ready;
    logic signed [15:0] angle_joint_one;
    logic signed [15:0] angle_joint_two;
    logic signed [15:0] angle_joint_three;
    logic signed [15:0] angle_joint_four;
    logic signed [15:0] angle_joint_five;
    logic signed [15:0] angle_joint_six;
    logic               pose_valid;
    logic               pose_ready;
    logic signed [17:0] rot_row0_col0, rot_row0_col1, rot_row0_col2;
    logic signed [17:0] rot_row1_col0, rot_row1_col1, rot_row1_col2;
    logic signed [17:0] rot_row2_col0, rot_row2_col1, rot_row2_col2;
    logic signed [18:0] pos_x, pos_y, pos_z;

    // predictor copy of the link registers
    logic signed [17:0] link_regs [6];
    tool_pose_t         pending_poses [$];
    int                 mismatch_count;
    bit                 long_hold_go;
    int                 burst_left;

    dh_forward_kinematics_six_joint_unit u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .angle_valid       (angle_valid),
        .angle_ready       (angle_ready),
        .angle_joint_one   (angle_joint_one),
        .angle_joint_two   (angle_joint_two),
        .angle_joint_three (angle_joint_three),
        .angle_joint_four  (angle_joint_four),
        .angle_joint_five  (angle_joint_five),
        .angle_joint_six   (angle_joint_six),
        .pose_valid        (pose_valid),
        .pose_ready        (pose_ready),
        .rot_row0_col0     (rot_row0_col0),
        .rot_row0_col1     (rot_row0_col1),
        .rot_row0_col2     (rot_row0_col2),
        .rot_row1_col0     (rot_row1_col0),
        .rot_row1_col1     (rot_row1_col1),
        .rot_row1_col2     (rot_row1_col2),
        .rot_row2_col0     (rot_row2_col0),
        .rot_row2_col1     (rot_row2_col1),
        .rot_row2_col2     (rot_row2_col2),
        .pos_x             (pos_x),
        .pos_y             (pos_y),
        .pos_z             (pos_z)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // run limit
    initial
    begin
        #3ms;
        $display("== FAIL ==");
        $finish;
    end

    // floor of (v + half) / 2^n
    function automatic longint round_shift(longint v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    // quarter-wave folded Taylor sine, Q30
    function automatic longint sine_q30(logic [31:0] phase);
        longint unsigned r, t, t2, acc;
        longint s;
        r = phase[29:0];
        t = phase[30] ? (64'd1 << 30) - r : r;
        t2 = (t * t) >> 30;
        acc = COEF_9 - ((t2 * COEF_11) >> 30);
        acc = COEF_7 - ((t2 * acc) >> 30);
        acc = COEF_5 - ((t2 * acc) >> 30);
        acc = COEF_3 - ((t2 * acc) >> 30);
        acc = COEF_1 - ((t2 * acc) >> 30);
        s = longint'((t * acc) >> 30);
        return phase[31] ? -s : s;
    endfunction

    // chain the six link transforms and round to the output formats
    function automatic tool_pose_t forward_pose(joint_angles_t ang);
        longint rot [3][3];
        longint nrot [3][3];
        longint pos [3];
        longint lk [3][3];
        longint lp [3];
        longint la [6];
        longint ld [6];
        longint s, c, acc, v;
        logic [31:0] phase;
        tool_pose_t res;
        for (int i = 0; i < 3; i++)
        begin
            pos[i] = 0;
            for (int j = 0; j < 3; j++)
                rot[i][j] = (i == j) ? UNIT_Q30 : 0;
        end
        for (int n = 0; n < 6; n++)
        begin
            la[n] = 0;
            ld[n] = 0;
        end
        ld[0] = longint'(link_regs[0]) * 256;
        la[2] = longint'(link_regs[1]) * 256;
        la[3] = longint'(link_regs[2]) * 256;
        ld[3] = longint'(link_regs[3]) * 256;
        ld[4] = longint'(link_regs[4]) * 256;
        ld[5] = longint'(link_regs[5]) * 256;
        for (int n = 0; n < 6; n++)
        begin
            phase = {ang[n], 16'h0000};
            s = sine_q30(phase);
            c = sine_q30(phase + 32'h4000_0000);
            lk[0] = '{c, -s, 0};
            lp[0] = la[n];
            case (LINK_TWIST[n])
                TWIST_NONE:
                begin
                    lk[1] = '{s, c, 0};
                    lk[2] = '{0, 0, UNIT_Q30};
                    lp[1] = 0;
                    lp[2] = ld[n];
                end
                TWIST_PLUS:
                begin
                    lk[1] = '{0, 0, -UNIT_Q30};
                    lk[2] = '{s, c, 0};
                    lp[1] = -ld[n];
                    lp[2] = 0;
                end
                default:
                begin
                    lk[1] = '{0, 0, UNIT_Q30};
                    lk[2] = '{-s, -c, 0};
                    lp[1] = ld[n];
                    lp[2] = 0;
                end
            endcase
            for (int i = 0; i < 3; i++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += rot[i][k] * lp[k];
                pos[i] += round_shift(acc, 30);
                for (int j = 0; j < 3; j++)
                begin
                    acc = 0;
                    for (int k = 0; k < 3; k++)
                        acc += rot[i][k] * lk[k][j];
                    nrot[i][j] = round_shift(acc, 30);
                end
            end
            rot = nrot;
        end
        for (int i = 0; i < 9; i++)
        begin
            v = round_shift(rot[i / 3][i % 3], 14);
            if (v > 65536)
                v = 65536;
            if (v < -65536)
                v = -65536;
            res.rot[i] = v[17:0];
        end
        for (int i = 0; i < 3; i++)
        begin
            v = round_shift(pos[i], 8);
            if (v > 262143)
                v = 262143;
            if (v < -262144)
                v = -262144;
            res.pos[i] = v[18:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // one register write; cfg_valid is left high for back-to-back writes
    task automatic write_link_reg(logic [2:0] idx, logic signed [17:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx <= dhfk_pkg::CFG_WRIST_THREE)
            link_regs[idx] = value;
    endtask

    task automatic write_all_links(logic signed [17:0] values [6]);
        write_link_reg(dhfk_pkg::CFG_BASE_HEIGHT, values[0]);
        write_link_reg(dhfk_pkg::CFG_UPPER_ARM, values[1]);
        write_link_reg(dhfk_pkg::CFG_FOREARM, values[2]);
        write_link_reg(dhfk_pkg::CFG_WRIST_ONE, values[3]);
        write_link_reg(dhfk_pkg::CFG_WRIST_TWO, values[4]);
        write_link_reg(dhfk_pkg::CFG_WRIST_THREE, values[5]);
        // indexes past the last register are ignored by the unit
        write_link_reg(3'd6, 18'h2AAAA);
        write_link_reg(3'd7, 18'h15555);
        cfg_valid <= 1'b0;
    endtask

    // one angle beat, then an optional gap in the sender's burst pattern
    task automatic send_angles(joint_angles_t ang, bit typed, tool_pose_t typed_pose,
                               bit no_gap);
        int gap;
        angle_valid <= 1'b1;
        angle_joint_one <= ang[0];
        angle_joint_two <= ang[1];
        angle_joint_three <= ang[2];
        angle_joint_four <= ang[3];
        angle_joint_five <= ang[4];
        angle_joint_six <= ang[5];
        do
            @(posedge clk);
        while (!angle_ready);
        pending_poses.push_back(typed ? typed_pose : forward_pose(ang));
        if (burst_left > 0)
            burst_left--;
        if (!no_gap && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = $urandom_range(1, 8);
            angle_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // sender goes idle so the last beat is not offered again
    task automatic wait_drained();
        angle_valid <= 1'b0;
        while (pending_poses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [15:0] pick_angle();
        case ($urandom_range(0, 3))
            0: return 16'(($urandom_range(0, 3) << 14) + $urandom_range(0, 6) - 3);
            1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic random_angles(int count, bit no_gap);
        joint_angles_t ang;
        tool_pose_t unused;
        for (int n = 0; n < count; n++)
        begin
            foreach (ang[j])
                ang[j] = pick_angle();
            send_angles(ang, 1'b0, unused, no_gap);
        end
    endtask

    // stimulus
    initial
    begin
        angle_row_t rows [$];
        angle_row_t row;
        tool_pose_t zero_pose;
        logic signed [17:0] regs_max [6];
        logic signed [17:0] regs_min [6];
        logic signed [17:0] regs_rand [6];
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        angle_valid <= 1'b0;
        angle_joint_one <= '0;
        angle_joint_two <= '0;
        angle_joint_three <= '0;
        angle_joint_four <= '0;
        angle_joint_five <= '0;
        angle_joint_six <= '0;
        mismatch_count = 0;
        long_hold_go = 1'b0;
        burst_left = 0;
        link_regs = '{dhfk_pkg::RST_BASE_HEIGHT, dhfk_pkg::RST_UPPER_ARM,
                      dhfk_pkg::RST_FOREARM, dhfk_pkg::RST_WRIST_ONE,
                      dhfk_pkg::RST_WRIST_TWO, dhfk_pkg::RST_WRIST_THREE};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // home pose with reset links: net twist of a quarter turn about x
        zero_pose.rot = '{18'sd65536, 18'sd0, 18'sd0,
                          18'sd0, 18'sd0, -18'sd65536,
                          18'sd0, 18'sd65536, 18'sd0};
        zero_pose.pos = '{-19'sd53559, -19'sd12547, -19'sd354};
        row.typed = 1'b1;
        row.pose = zero_pose;
        row.angles = '{0, 0, 0, 0, 0, 0};
        rows.push_back(row);
        row.typed = 1'b0;
        row.angles = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
        rows.push_back(row);
        row.angles = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
        rows.push_back(row);
        row.angles = '{16384, 16384, 16384, 16384, 16384, 16384};
        rows.push_back(row);
        row.angles = '{-16384, -16384, -16384, -16384, -16384, -16384};
        rows.push_back(row);
        row.angles = '{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA};
        rows.push_back(row);
        row.angles = '{16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555};
        rows.push_back(row);
        row.angles = '{16'sh0001, 16'shFFFF, 16'sh4001, 16'sh3FFF, 16'shC000, 16'sh8001};
        rows.push_back(row);
        // one joint at a time
        for (int j = 0; j < 6; j++)
        begin
            row.angles = '{0, 0, 0, 0, 0, 0};
            row.angles[j] = 16'sd8192;
            rows.push_back(row);
        end
        foreach (rows[r])
            send_angles(rows[r].angles, rows[r].typed, rows[r].pose, 1'b0);
        wait_drained();

        // longest links, positions reach saturation
        angle_valid <= 1'b0;
        regs_max = '{18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF};
        write_all_links(regs_max);
        random_angles(60, 1'b0);
        // receiver holds off while the sender keeps offering beats
        long_hold_go = 1'b1;
        random_angles(60, 1'b1);
        wait_drained();

        angle_valid <= 1'b0;
        regs_min = '{18'sh20000, 18'sh20000, 18'sh20000, 18'sh20000, 18'sh20000, 18'sh20000};
        write_all_links(regs_min);
        random_angles(100, 1'b0);
        wait_drained();

        for (int p = 0; p < 2; p++)
        begin
            angle_valid <= 1'b0;
            foreach (regs_rand[j])
                regs_rand[j] = 18'($urandom());
            write_all_links(regs_rand);
            random_angles((RANDOM_ITEMS - 220) / 2, 1'b0);
            wait_drained();
        end
        angle_valid <= 1'b0;

        if (pending_poses.size() != 0)
        begin
            $display("%0d poses never came out", pending_poses.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // receiver stall pattern with one long hold-off
    initial
    begin
        int hold_left;
        int mode_left;
        int mode;
        hold_left = 0;
        mode_left = 0;
        mode = 0;
        pose_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_go)
            begin
                long_hold_go = 1'b0;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                pose_ready <= 1'b0;
            end
            else if (mode == 0)
                pose_ready <= 1'b1;
            else if (mode == 1)
                pose_ready <= $urandom_range(0, 1);
            else
                pose_ready <= ($urandom_range(0, 3) == 0);
        end
    end

    // compare each pose beat with the oldest prediction
    always @(posedge clk)
    begin
        logic signed [17:0] got_rot [9];
        logic signed [18:0] got_pos [3];
        tool_pose_t want;
        if (rst_n && pose_valid && pose_ready)
        begin
            got_rot = '{rot_row0_col0, rot_row0_col1, rot_row0_col2,
                        rot_row1_col0, rot_row1_col1, rot_row1_col2,
                        rot_row2_col0, rot_row2_col1, rot_row2_col2};
            got_pos = '{pos_x, pos_y, pos_z};
            if (pending_poses.size() == 0)
                report_mismatch("unexpected pose beat", 1, 0);
            else
            begin
                want = pending_poses.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got_rot[i] !== want.rot[i])
                        report_mismatch($sformatf("rot[%0d][%0d]", i / 3, i % 3),
                                        got_rot[i], want.rot[i]);
                for (int i = 0; i < 3; i++)
                    if (got_pos[i] !== want.pos[i])
                        report_mismatch($sformatf("pos[%0d]", i), got_pos[i], want.pos[i]);
            end
        end
    end

endmodule

FILE: dh_forward_kinematics_six_joint_unit.f
rtl/core/dhfk_pkg.sv
rtl/core/dhfk_sin.sv
rtl/core/dhfk_link.sv
rtl/core/dh_forward_kinematics_six_joint_unit.sv
tb/sv/dh_forward_kinematics_six_joint_unit_tb.sv
